@@ design/mmv_pkg.sv @@
// ----------------------------------------------------------------------------
// mmv_pkg
// Shared types and constants for the modular exponentiation verify block.
// ----------------------------------------------------------------------------
package mmv_pkg;

    // Width of every field on the block's ports.
    localparam int FIELD_WIDTH = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_BIT,
        ST_MUL,
        ST_SQR,
        ST_DONE
    } t_state;

endpackage

@@ design/mmv_mulmod.sv @@
// ----------------------------------------------------------------------------
// mmv_mulmod
// Shift-and-add modular multiplier: x * y mod m, one bit of y per cycle,
// most significant bit first. Requires x < m and m != 0.
// ----------------------------------------------------------------------------
module mmv_mulmod #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_x,
    input  logic [WIDTH-1:0] i_y,
    input  logic [WIDTH-1:0] i_m,
    output logic             o_done,
    output logic [WIDTH-1:0] o_result
);

    localparam int CW = $clog2(WIDTH + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] r_x;
    logic [WIDTH-1:0] r_y;
    logic [WIDTH-1:0] r_m;
    logic [WIDTH-1:0] n_acc;
    logic [WIDTH-1:0] dbl;

    // (a + b) mod m for a, b < m; the plain sum is only used when it stays below m.
    function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] a,
                                                 input logic [WIDTH-1:0] b,
                                                 input logic [WIDTH-1:0] m);
        logic [WIDTH-1:0] gap;
        gap = m - b;
        add_mod = (a >= gap) ? (a - gap) : (a + b);
    endfunction

    always_comb begin
        dbl   = add_mod(r_acc, r_acc, r_m);
        n_acc = r_y[WIDTH-1] ? add_mod(dbl, r_x, r_m) : dbl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_x   <= i_x;
            r_y   <= i_y;
            r_m   <= i_m;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_y   <= {r_y[WIDTH-2:0], 1'b0};
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule

@@ design/modular_exponentiation_verify_top.sv @@
// ----------------------------------------------------------------------------
// modular_exponentiation_verify_top
// Right-to-left square-and-multiply modular exponentiation with a compare
// against an expected value, for RSA style sign and verify checks.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; busy then stays high
// until the result has been shown. The result is on the output ports for
// exactly one cycle, marked by o_result_valid, and must be captured then
// since it cannot be held off. All work runs through one shift-and-add
// modular multiplier. One product reduces the base, then each exponent
// bit up to the highest set one costs a multiply if it is set and a
// square if it lies below the highest set bit. A zero modulus skips the
// multiplier and goes straight to the result.
// ----------------------------------------------------------------------------
module modular_exponentiation_verify_top #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [mmv_pkg::FIELD_WIDTH-1:0]  i_base_value,
    input  logic [mmv_pkg::FIELD_WIDTH-1:0]  i_exponent,
    input  logic [mmv_pkg::FIELD_WIDTH-1:0]  i_modulus,
    input  logic [mmv_pkg::FIELD_WIDTH-1:0]  i_expected_value,
    output logic                             o_result_valid,
    output logic [mmv_pkg::FIELD_WIDTH-1:0]  o_power_result,
    output logic                             o_matches_res,
    output logic                             o_modulus_error
);

    localparam int W = OPERAND_WIDTH;

    mmv_pkg::t_state r_state, n_state;

    logic [W-1:0] r_base, n_base;
    logic [W-1:0] r_expo, n_expo;
    logic [W-1:0] r_mod, n_mod;
    logic [W-1:0] r_expect, n_expect;
    logic [W-1:0] r_acc, n_acc;
    logic         r_err, n_err;

    logic         mm_start;
    logic [W-1:0] mm_x;
    logic [W-1:0] mm_y;
    logic [W-1:0] mm_m;
    logic         mm_done;
    logic [W-1:0] mm_result;

    logic [W-1:0] in_base;
    logic [W-1:0] in_mod;
    logic         mod_is_one;

    assign in_base    = W'(i_base_value);
    assign in_mod     = W'(i_modulus);
    assign mod_is_one = (r_mod == W'(1));

    mmv_mulmod #(
        .WIDTH (W)
    ) u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mm_start),
        .i_x      (mm_x),
        .i_y      (mm_y),
        .i_m      (mm_m),
        .o_done   (mm_done),
        .o_result (mm_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mmv_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base   <= n_base;
        r_expo   <= n_expo;
        r_mod    <= n_mod;
        r_expect <= n_expect;
        r_acc    <= n_acc;
        r_err    <= n_err;
    end

    always_comb begin
        n_state  = r_state;
        n_base   = r_base;
        n_expo   = r_expo;
        n_mod    = r_mod;
        n_expect = r_expect;
        n_acc    = r_acc;
        n_err    = r_err;
        mm_start = 1'b0;
        mm_x     = r_base;
        mm_y     = r_base;
        mm_m     = r_mod;

        case (r_state)
            mmv_pkg::ST_IDLE: begin
                if (start) begin
                    n_base   = in_base;
                    n_expo   = W'(i_exponent);
                    n_mod    = in_mod;
                    n_expect = W'(i_expected_value);
                    if (in_mod == '0) begin
                        n_err   = 1'b1;
                        n_acc   = '0;
                        n_state = mmv_pkg::ST_DONE;
                    end else begin
                        // The base is reduced as (1 mod m) * base mod m.
                        n_err    = 1'b0;
                        n_acc    = W'(1);
                        mm_start = 1'b1;
                        mm_x     = (in_mod == W'(1)) ? '0 : W'(1);
                        mm_y     = in_base;
                        mm_m     = in_mod;
                        n_state  = mmv_pkg::ST_REDUCE;
                    end
                end
            end
            mmv_pkg::ST_REDUCE: begin
                if (mm_done) begin
                    n_base  = mm_result;
                    n_state = mmv_pkg::ST_BIT;
                end
            end
            mmv_pkg::ST_BIT: begin
                if (r_expo == '0) begin
                    n_state = mmv_pkg::ST_DONE;
                end else if (r_expo[0]) begin
                    // The running result starts at 1, which is not reduced when m is 1.
                    mm_start = 1'b1;
                    mm_x     = mod_is_one ? '0 : r_acc;
                    mm_y     = r_base;
                    n_state  = mmv_pkg::ST_MUL;
                end else begin
                    mm_start = 1'b1;
                    n_expo   = r_expo >> 1;
                    n_state  = mmv_pkg::ST_SQR;
                end
            end
            mmv_pkg::ST_MUL: begin
                if (mm_done) begin
                    n_acc  = mm_result;
                    n_expo = r_expo >> 1;
                    // The square after the highest set bit would never be used.
                    if ((r_expo >> 1) == '0) begin
                        n_state = mmv_pkg::ST_DONE;
                    end else begin
                        mm_start = 1'b1;
                        n_state  = mmv_pkg::ST_SQR;
                    end
                end
            end
            mmv_pkg::ST_SQR: begin
                if (mm_done) begin
                    n_base  = mm_result;
                    n_state = mmv_pkg::ST_BIT;
                end
            end
            mmv_pkg::ST_DONE: begin
                n_state = mmv_pkg::ST_IDLE;
            end
            default: begin
                n_state = mmv_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy            = (r_state != mmv_pkg::ST_IDLE);
    assign o_result_valid  = (r_state == mmv_pkg::ST_DONE);
    assign o_power_result  = mmv_pkg::FIELD_WIDTH'(r_acc);
    assign o_matches_res   = !r_err && (r_acc == r_expect);
    assign o_modulus_error = r_err;

endmodule

@@ design/mmv_checker.sv @@
// ----------------------------------------------------------------------------
// mmv_checker
// Port-level checks for the modular exponentiation verify block.
// ----------------------------------------------------------------------------
module mmv_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            o_result_valid,
    input logic [mmv_pkg::FIELD_WIDTH-1:0] o_power_result,
    input logic                            o_matches_res,
    input logic                            o_modulus_error
);

    // An accepted word keeps the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after an accepted word");

    // A result is shown only while its word is still in flight.
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> busy)
        else $error("result shown while idle");

    // The strobe lasts one cycle and the block is free right after it.
    a_valid_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> (!o_result_valid && !busy))
        else $error("result strobe not followed by idle");

    // A zero modulus gives a zero result that never matches.
    a_error_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_modulus_error) |-> (o_power_result == '0 && !o_matches_res))
        else $error("modulus error with nonzero result or match");

endmodule

bind modular_exponentiation_verify_top mmv_checker u_mmv_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_result_valid  (o_result_valid),
    .o_power_result  (o_power_result),
    .o_matches_res   (o_matches_res),
    .o_modulus_error (o_modulus_error)
);
